FILE: hw/rtl/snzs_pkg.sv
// Package for the strip neighbor zero-suppression block.
// Holds field widths, register and algorithm codes, payload and window types.
// No dependencies; used by every module of the block.
package snzs_pkg;

  localparam int STRIP_W   = 10;
  localparam int ADC_W     = 10;
  localparam int ALG_W     = 3;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 2;

  localparam int STRIPS_PER_APV_DEF = 128;
  localparam int WIN_DEPTH          = 4;
  localparam int LANES              = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ALGORITHM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR  = 2'd2;

  // Acceptance rules
  localparam logic [ALG_W-1:0] ALG_LOW_ONLY = 3'd1;
  localparam logic [ALG_W-1:0] ALG_NB_LOW   = 3'd2;
  localparam logic [ALG_W-1:0] ALG_NB_HIGH  = 3'd3;
  localparam logic [ALG_W-1:0] ALG_CLUSTER  = 3'd4;

  localparam logic [ALG_W-1:0] ALG_RESET      = ALG_CLUSTER;
  localparam logic [ADC_W-1:0] LOW_THR_RESET  = 10'd2;
  localparam logic [ADC_W-1:0] HIGH_THR_RESET = 10'd5;

  typedef struct packed {
    logic [STRIP_W-1:0] strip;
    logic [ADC_W-1:0]   adc;
    logic               present;
    logic               last_strip;
  } in_t;

  typedef struct packed {
    logic [STRIP_W-1:0] out_strip;
    logic [ADC_W-1:0]   out_adc;
    logic               last_of_run;
  } out_t;

  // Contents of one window position
  typedef struct packed {
    logic             present;
    logic [ADC_W-1:0] adc;
  } win_t;

  // One window position after threshold compare
  typedef struct packed {
    logic present;
    logic ge_lo;
    logic ge_hi;
  } slot_t;

  // APV boundary flags for the four neighbors of a center strip
  typedef struct packed {
    logic p2;
    logic p1;
    logic n1;
    logic n2;
  } bnd_t;

  typedef struct packed {
    logic [ALG_W-1:0] algorithm;
    slot_t            p2;
    slot_t            p1;
    slot_t            center;
    slot_t            n1;
    slot_t            n2;
    bnd_t             bnd;
  } dec_in_t;

endpackage

FILE: hw/rtl/snzs_cell.sv
// One position of the strip window: holds ADC count and present flag.
// Loads from its upstream neighbor on shift, clears on module flush.
// Depends on snzs_pkg.
module snzs_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift,
  input  logic          clear,
  input  snzs_pkg::win_t d_in,
  output snzs_pkg::win_t q
);
  import snzs_pkg::*;

  win_t win_r;
  win_t win_nxt;

  always_comb begin
    win_nxt = win_r;
    if (clear) begin
      win_nxt = '0;
    end else if (shift) begin
      win_nxt = d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else begin
      win_r <= win_nxt;
    end
  end

  assign q = win_r;

endmodule

FILE: hw/rtl/snzs_decide.sv
// Keep/drop decision for one center strip from threshold and boundary flags.
// An absent neighbor reads as below any threshold, or above it at an APV edge.
// Depends on snzs_pkg.
module snzs_decide (
  input  snzs_pkg::dec_in_t d,
  output logic              keep
);
  import snzs_pkg::*;

  logic p2_lo, p1_lo, p1_hi, n1_lo, n1_hi, n2_lo;
  logic c_lo, c_hi;

  always_comb begin
    p2_lo = d.p2.present ? d.p2.ge_lo : d.bnd.p2;
    p1_lo = d.p1.present ? d.p1.ge_lo : d.bnd.p1;
    p1_hi = d.p1.present ? d.p1.ge_hi : d.bnd.p1;
    n1_lo = d.n1.present ? d.n1.ge_lo : d.bnd.n1;
    n1_hi = d.n1.present ? d.n1.ge_hi : d.bnd.n1;
    n2_lo = d.n2.present ? d.n2.ge_lo : d.bnd.n2;
    c_lo  = d.center.ge_lo;
    c_hi  = d.center.ge_hi;

    unique case (d.algorithm)
      ALG_LOW_ONLY: keep = c_lo;
      ALG_NB_LOW:   keep = c_hi || (c_lo && (p1_lo || n1_lo));
      ALG_NB_HIGH:  keep = c_hi || (c_lo && (p1_hi || n1_hi));
      ALG_CLUSTER: begin
        keep = c_hi || (c_lo && (p1_lo || n1_lo)) ||
               (!c_lo && ((p1_hi && n1_hi) ||
                          (p1_hi && n1_lo && n2_lo) ||
                          (n1_hi && p1_lo && p2_lo) ||
                          (n1_lo && n2_lo && p1_lo && p2_lo)));
      end
      default:      keep = 1'b0;
    endcase
  end

endmodule

FILE: hw/rtl/strip_neighbour_zero_suppress.sv
// Strip neighbor zero suppression: four-cell window chain, threshold stage,
// per-lane APV position and decision, and a three-slot result serializer.
// Path: an item's first result passes the stage 1 and serializer registers
//   before it transfers; a strip is decided by the item two strips later,
//   or by the last strip of its module.
// Throughput: one item per cycle while the serializer is free; an item that
//   ends a module yields up to three results, which leave one per cycle while
//   out_ready is high; the input stalls while more than one result waits.
// Reset (rst_n low, synchronous): window and fill count cleared, registers
//   back to rule 4 with thresholds 2 and 5, pipeline and serializer empty.
module strip_neighbour_zero_suppress #(
  parameter int STRIPS_PER_APV = snzs_pkg::STRIPS_PER_APV_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  snzs_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output snzs_pkg::out_t                 out_data,
  input  logic                           cfg_we,
  input  logic [snzs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [snzs_pkg::CFG_W-1:0]     cfg_data
);
  import snzs_pkg::*;

  // Position within an APV is found by a reciprocal multiply in the first
  // stage and a constant multiply, subtract and one correction in the second.
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = $clog2((1 << RECIP_SHIFT) / STRIPS_PER_APV + 1);
  localparam int PROD_W      = STRIP_W + RECIP_W;
  localparam int QW          = PROD_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << RECIP_SHIFT) / STRIPS_PER_APV);
  localparam logic [STRIP_W:0] SPA_X   = (STRIP_W+1)'(STRIPS_PER_APV);
  localparam logic [STRIP_W:0] EDGE_P1 = '0;
  localparam logic [STRIP_W:0] EDGE_P2 = (STRIP_W+1)'(1);
  localparam logic [STRIP_W:0] EDGE_N1 = SPA_X - (STRIP_W+1)'(1);
  localparam logic [STRIP_W:0] EDGE_N2 = SPA_X - (STRIP_W+1)'(2);
  localparam int SLOTS = WIN_DEPTH + 1;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [ALG_W-1:0] alg_r, alg_nxt;
  logic [ADC_W-1:0] low_thr_r, low_thr_nxt;
  logic [ADC_W-1:0] high_thr_r, high_thr_nxt;

  always_comb begin
    alg_nxt      = alg_r;
    low_thr_nxt  = low_thr_r;
    high_thr_nxt = high_thr_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_ALGORITHM: alg_nxt      = cfg_data[ALG_W-1:0];
        REG_LOW_THR:   low_thr_nxt  = cfg_data[ADC_W-1:0];
        REG_HIGH_THR:  high_thr_nxt = cfg_data[ADC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alg_r      <= ALG_RESET;
      low_thr_r  <= LOW_THR_RESET;
      high_thr_r <= HIGH_THR_RESET;
    end else begin
      alg_r      <= alg_nxt;
      low_thr_r  <= low_thr_nxt;
      high_thr_r <= high_thr_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Handshake control
  // ---------------------------------------------------------------------
  logic       in_fire;
  logic       out_fire;
  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_adv;
  logic       ser_free;
  logic       single_left;
  logic [LANES-1:0] ser_mask_r, ser_mask_nxt;

  assign out_valid   = |ser_mask_r;
  assign out_fire    = out_valid && out_ready;
  // At most one result left: serializer empties this cycle if it transfers
  assign single_left = (ser_mask_r & (ser_mask_r - 3'd1)) == 3'd0;
  assign ser_free    = !out_valid || (out_ready && single_left);
  assign s1_adv      = s1_valid_r && ser_free;
  assign in_ready    = !s1_valid_r || ser_free;
  assign in_fire     = in_valid && in_ready;

  // ---------------------------------------------------------------------
  // Window: a chain of cells, oldest at position 0, advancing on transfer
  // ---------------------------------------------------------------------
  win_t win_q [WIN_DEPTH];
  win_t win_d [WIN_DEPTH];
  logic [2:0] fill_r, fill_nxt;
  logic win_clear;

  assign win_clear = in_fire && in_data.last_strip;

  genvar gi;
  generate
    for (gi = 0; gi < WIN_DEPTH; gi++) begin : g_win
      if (gi == WIN_DEPTH - 1) begin : g_head
        assign win_d[gi] = '{present: in_data.present, adc: in_data.adc};
      end else begin : g_body
        assign win_d[gi] = win_q[gi+1];
      end
      snzs_cell u_win (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (in_fire),
        .clear (win_clear),
        .d_in  (win_d[gi]),
        .q     (win_q[gi])
      );
    end
  endgenerate

  // Count strips held, saturating at the window depth; drop to zero on flush
  always_comb begin
    fill_nxt = fill_r;
    if (win_clear) begin
      fill_nxt = '0;
    end else if (in_fire && fill_r < 3'(WIN_DEPTH)) begin
      fill_nxt = fill_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: threshold compares, center strip numbers, APV quotient
  // ---------------------------------------------------------------------
  win_t               cur_slot [SLOTS];
  slot_t              s1_slot_r [SLOTS];
  logic [STRIP_W-1:0] s1_cstrip_r [LANES];
  logic [QW-1:0]      s1_q_r [LANES];
  logic [ADC_W-1:0]   s1_adc_r [LANES];
  logic [LANES-1:0]   s1_elig_r;
  logic [STRIP_W-1:0] cstrip [LANES];
  logic [PROD_W-1:0]  prod [LANES];
  logic [LANES-1:0]   elig;

  generate
    for (gi = 0; gi < SLOTS; gi++) begin : g_cur
      if (gi == SLOTS - 1) begin : g_in
        assign cur_slot[gi] = '{present: in_data.present, adc: in_data.adc};
      end else begin : g_win
        assign cur_slot[gi] = win_q[gi];
      end
    end

    // Lane l decides the strip lagging the current one by LANES-1-l
    for (gi = 0; gi < LANES; gi++) begin : g_lane1
      assign cstrip[gi] = in_data.strip - STRIP_W'(LANES - 1 - gi);
      assign prod[gi]   = PROD_W'(cstrip[gi]) * PROD_W'(RECIP);
    end
  endgenerate

  // Lane 0 runs on every item once two strips are held; lanes 1 and 2 only on the module's last strip
  assign elig[0] = (fill_r >= 3'd2) && cur_slot[2].present;
  assign elig[1] = in_data.last_strip && (fill_r >= 3'd1) && cur_slot[3].present;
  assign elig[2] = in_data.last_strip && cur_slot[4].present;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Payload of stage 1: hold unless a new item transfers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int s = 0; s < SLOTS; s++) begin
        s1_slot_r[s] <= '{present: cur_slot[s].present,
                          ge_lo:   cur_slot[s].adc >= low_thr_r,
                          ge_hi:   cur_slot[s].adc >= high_thr_r};
      end
      for (int l = 0; l < LANES; l++) begin
        s1_cstrip_r[l] <= cstrip[l];
        s1_q_r[l]      <= prod[l][RECIP_SHIFT +: QW];
        s1_adc_r[l]    <= cur_slot[l+2].adc;
      end
      s1_elig_r <= elig;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: APV position, boundary flags and decisions per lane
  // ---------------------------------------------------------------------
  slot_t            s2_slot [SLOTS + 2];
  logic [LANES-1:0] dec_keep;
  logic [LANES-1:0] s2_keep;

  generate
    for (gi = 0; gi < SLOTS + 2; gi++) begin : g_s2slot
      if (gi < SLOTS) begin : g_held
        assign s2_slot[gi] = s1_slot_r[gi];
      end else begin : g_beyond
        // Past the current strip nothing is known yet: absent
        assign s2_slot[gi] = '0;
      end
    end

    for (gi = 0; gi < LANES; gi++) begin : g_lane2
      logic [STRIP_W-1:0] qs;
      logic [STRIP_W:0]   r_est;
      logic [STRIP_W:0]   pos;
      dec_in_t            din;

      assign qs    = STRIP_W'(s1_q_r[gi] * STRIPS_PER_APV);
      assign r_est = {1'b0, s1_cstrip_r[gi] - qs};
      assign pos   = (r_est >= SPA_X) ? (r_est - SPA_X) : r_est;

      assign din.algorithm = alg_r;
      assign din.p2        = s2_slot[gi];
      assign din.p1        = s2_slot[gi+1];
      assign din.center    = s2_slot[gi+2];
      assign din.n1        = s2_slot[gi+3];
      assign din.n2        = s2_slot[gi+4];
      assign din.bnd.p2    = pos == EDGE_P2;
      assign din.bnd.p1    = pos == EDGE_P1;
      assign din.bnd.n1    = pos == EDGE_N1;
      assign din.bnd.n2    = pos == EDGE_N2;

      snzs_decide u_dec (
        .d    (din),
        .keep (dec_keep[gi])
      );
    end
  endgenerate

  assign s2_keep = dec_keep & s1_elig_r;

  // ---------------------------------------------------------------------
  // Serializer: one slot per lane, emit the lowest kept lane first
  // ---------------------------------------------------------------------
  logic [STRIP_W-1:0] ser_strip_r [LANES];
  logic [ADC_W-1:0]   ser_adc_r [LANES];

  always_comb begin
    ser_mask_nxt = ser_mask_r;
    if (s1_adv) begin
      ser_mask_nxt = s2_keep;
    end else if (out_fire) begin
      ser_mask_nxt = ser_mask_r & (ser_mask_r - 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_mask_r <= '0;
    end else begin
      ser_mask_r <= ser_mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      for (int l = 0; l < LANES; l++) begin
        ser_strip_r[l] <= s1_cstrip_r[l];
        ser_adc_r[l]   <= s1_adc_r[l];
      end
    end
  end

  always_comb begin
    if (ser_mask_r[0]) begin
      out_data.out_strip = ser_strip_r[0];
      out_data.out_adc   = ser_adc_r[0];
    end else if (ser_mask_r[1]) begin
      out_data.out_strip = ser_strip_r[1];
      out_data.out_adc   = ser_adc_r[1];
    end else begin
      out_data.out_strip = ser_strip_r[2];
      out_data.out_adc   = ser_adc_r[2];
    end
    out_data.last_of_run = single_left;
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.last_strip |=> (fill_r == 3'd0) &&
      !win_q[0].present && !win_q[1].present &&
      !win_q[2].present && !win_q[3].present)
    else $error("window not cleared after module flush");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= 3'(WIN_DEPTH))
    else $error("window fill count beyond depth");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_elig_r))
    else $error("stage 1 item lost while serializer busy");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !out_data.last_of_run |=> out_valid)
    else $error("result run ended without last_of_run");

endmodule
